>>> hw/rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared constants and types for the CRC-checked frame decoder: header
// layout, counter widths, CRC-32 constants, register indexes, status codes.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned HDR_LEN    = 20;
  localparam int unsigned HDR_IDX_W  = 5;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [31:0]      CRC_INIT  = 32'hffff_ffff;
  localparam logic [31:0]      CRC_POLY  = 32'hedb8_8320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MAGIC      = 1'b0,
    REG_PROTOCOL_VERSION = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_INDEX   = 3'd5,
    ST_ZERO_ID = 3'd6,
    ST_CRC     = 3'd7
  } status_t;

endpackage

>>> hw/rtl/cfd_crc_step.sv
// ----------------------------------------------------------------------------
// cfd_crc_step
// One byte step of the reflected CRC-32 (polynomial 0xedb88320), eight bit
// steps unrolled into one combinational update.
// ----------------------------------------------------------------------------
module cfd_crc_step (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  logic [31:0] c;

  always_comb begin
    c = crc_in ^ {24'b0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (cfd_pkg::CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

>>> hw/rtl/crc_checked_frame_decoder.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_decoder
// Length-prefixed frame decoder: parses a 20-byte little-endian header,
// passes payload bytes out, checks CRC-32 and reports status at frame end.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle when the result channel is not stalled;
// the CRC byte step and the header checks sit in the single stage between
// the input register and the result register.
// Reset (synchronous, rst_n low): byte counter to zero, CRC to all ones,
// magic and version registers to zero, both pipeline valids cleared.
// The 20-byte header store is not reset.
module crc_checked_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_frame_byte,
  input  logic                             in_last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_has_payload,
  output logic [7:0]                       out_payload_byte,
  output logic                             out_frame_end,
  output logic [2:0]                       out_status,
  output logic [7:0]                       out_frame_kind,
  output logic [7:0]                       out_frame_flags,
  output logic [15:0]                      out_session_id,
  output logic [31:0]                      out_message_id,
  output logic [7:0]                       out_chunk_index,
  output logic [7:0]                       out_chunk_count,
  output logic [15:0]                      out_payload_length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW = cfd_pkg::CNT_W;

  logic [15:0]   magic_r;
  logic [7:0]    version_r;

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;

  logic [CW-1:0] cnt_r;
  logic [31:0]   crc_r;
  logic [7:0]    hdr_r [cfd_pkg::HDR_LEN];

  logic          out_valid_r;
  logic          has_payload_r;
  logic [7:0]    payload_byte_r;
  logic          frame_end_r;
  logic [2:0]    status_r;
  logic [7:0]    kind_r;
  logic [7:0]    flags_r;
  logic [15:0]   session_r;
  logic [31:0]   msg_r;
  logic [7:0]    idx_r;
  logic [7:0]    cnt_field_r;
  logic [15:0]   plen_r;

  logic          adv;
  logic          fire;
  logic          in_hdr;
  logic          is_payload;
  logic          has_result;
  logic          short_frame;
  logic [7:0]    hdr_eff [cfd_pkg::HDR_LEN];
  logic [15:0]   plen;
  logic [31:0]   msg;
  logic [31:0]   crc_exp;
  logic [CW-1:0] pay_off;
  logic [CW-1:0] total;
  logic [31:0]   crc_stepped;
  logic [31:0]   crc_nxt;
  logic [CW-1:0] cnt_nxt;
  cfd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfd_pkg::REG_FRAME_MAGIC:      magic_r   <= cfg_data;
        cfd_pkg::REG_PROTOCOL_VERSION: version_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // advance when the result slot is empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign fire     = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_frame_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < cfd_pkg::HDR_LEN; i++) begin
      hdr_eff[i] = (cnt_r == CW'(i)) ? s1_byte_r : hdr_r[i];
    end
  end

  assign plen    = {hdr_eff[15], hdr_eff[14]};
  assign msg     = {hdr_eff[11], hdr_eff[10], hdr_eff[9], hdr_eff[8]};
  assign crc_exp = {hdr_eff[19], hdr_eff[18], hdr_eff[17], hdr_eff[16]};

  assign in_hdr     = cnt_r < CW'(cfd_pkg::HDR_LEN);
  assign pay_off    = cnt_r - CW'(cfd_pkg::HDR_LEN);
  assign is_payload = !in_hdr && (pay_off < {1'b0, plen});
  assign has_result = is_payload || s1_last_r;

  cfd_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_stepped)
  );

  assign crc_nxt = is_payload ? crc_stepped : crc_r;
  assign total   = (cnt_r < cfd_pkg::COUNT_MAX) ? cnt_r + CW'(1) : cfd_pkg::COUNT_MAX;
  assign cnt_nxt = s1_last_r ? '0 : total;
  assign short_frame = total < CW'(cfd_pkg::HDR_LEN);

  always_comb begin
    if (short_frame) begin
      st = cfd_pkg::ST_SHORT;
    end else if ({hdr_eff[1], hdr_eff[0]} != magic_r) begin
      st = cfd_pkg::ST_MAGIC;
    end else if (hdr_eff[2] != version_r) begin
      st = cfd_pkg::ST_VERSION;
    end else if (total != CW'(cfd_pkg::HDR_LEN) + {1'b0, plen}) begin
      st = cfd_pkg::ST_LENGTH;
    end else if (hdr_eff[13] == 8'd0 || hdr_eff[12] >= hdr_eff[13]) begin
      st = cfd_pkg::ST_INDEX;
    end else if (msg == 32'd0) begin
      st = cfd_pkg::ST_ZERO_ID;
    end else if (~crc_nxt != crc_exp) begin
      st = cfd_pkg::ST_CRC;
    end else begin
      st = cfd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= cfd_pkg::CRC_INIT;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      crc_r <= s1_last_r ? cfd_pkg::CRC_INIT : crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_hdr) begin
      hdr_r[cnt_r[cfd_pkg::HDR_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      has_payload_r  <= is_payload;
      payload_byte_r <= is_payload ? s1_byte_r : 8'd0;
      frame_end_r    <= s1_last_r;
      if (s1_last_r && !short_frame) begin
        status_r    <= st;
        kind_r      <= hdr_eff[3];
        flags_r     <= hdr_eff[4];
        session_r   <= {hdr_eff[7], hdr_eff[6]};
        msg_r       <= msg;
        idx_r       <= hdr_eff[12];
        cnt_field_r <= hdr_eff[13];
        plen_r      <= plen;
      end else begin
        status_r    <= s1_last_r ? st : cfd_pkg::ST_OK;
        kind_r      <= '0;
        flags_r     <= '0;
        session_r   <= '0;
        msg_r       <= '0;
        idx_r       <= '0;
        cnt_field_r <= '0;
        plen_r      <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_has_payload    = has_payload_r;
  assign out_payload_byte   = payload_byte_r;
  assign out_frame_end      = frame_end_r;
  assign out_status         = status_r;
  assign out_frame_kind     = kind_r;
  assign out_frame_flags    = flags_r;
  assign out_session_id     = session_r;
  assign out_message_id     = msg_r;
  assign out_chunk_index    = idx_r;
  assign out_chunk_count    = cnt_field_r;
  assign out_payload_length = plen_r;

endmodule

>>> hw/rtl/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the frame decoder's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module cfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_has_payload,
  input logic [7:0]  out_payload_byte,
  input logic        out_frame_end,
  input logic [2:0]  out_status,
  input logic [31:0] out_message_id,
  input logic [15:0] out_payload_length
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_status_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_status == cfd_pkg::ST_OK)
    else $error("status set on a transaction that does not end a frame");

  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_payload |-> out_payload_byte == 8'd0)
    else $error("payload byte nonzero without payload flag");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && out_status == cfd_pkg::ST_SHORT
      |-> out_message_id == 32'd0 && out_payload_length == 16'd0 && !out_has_payload)
    else $error("short frame reports header fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind crc_checked_frame_decoder cfd_checker u_cfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_has_payload    (out_has_payload),
  .out_payload_byte   (out_payload_byte),
  .out_frame_end      (out_frame_end),
  .out_status         (out_status),
  .out_message_id     (out_message_id),
  .out_payload_length (out_payload_length)
);
